// ===== hw/rtl/dlfb_pkg.sv =====
// ----------------------------------------------------------------------------
// dlfb_pkg
// shared types and constants for the line draw engine and its pixel store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dlfb_pkg;

  localparam int COORD_W = 10;
  localparam int DIM_W   = 11;
  localparam int COLOR_W = 16;
  localparam int FRAC_MAX = 16;
  localparam int STEP_W  = FRAC_MAX + 2;
  localparam int PROD_W  = COORD_W + DIM_W;
  localparam int IDX_W   = PROD_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic MODE_DRAW = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] FRAME_DIM_RESET = 11'd240;

  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam int QCW    = 2;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [COLOR_W-1:0] color;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_value;
    logic [COORD_W-1:0] pixels_written;
  } out_item_t;

  typedef struct packed {
    logic                     rd;
    logic [COORD_W-1:0]       x0;
    logic [COORD_W-1:0]       y0;
    logic [COORD_W-1:0]       len;
    logic signed [STEP_W-1:0] stx;
    logic signed [STEP_W-1:0] sty;
    logic [COLOR_W-1:0]       color;
  } cmd_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_PREP,
    FR_DIV,
    FR_PUSH
  } fr_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_FLUSH,
    BK_DONE
  } bk_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dda_line_framebuffer_draw.sv =====
// ----------------------------------------------------------------------------
// dda_line_framebuffer_draw
// fixed-point dda line engine and pixel reader over a 16-bit pixel store
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_stall   in_data   (dlfb_pkg::in_item_t)
//  out_     output     out_valid/out_stall out_data  (dlfb_pkg::out_item_t)
//  cfg_     input      cfg_we              cfg_index, cfg_wdata
//
//  front: takes an item, classifies it, runs a bit-serial divide for a draw
//  of nonzero length and queues it, one item at a time; back: walks a line
//  of L steps, one store write per cycle, or does one store read. front and
//  back overlap through a 2-entry queue.
//  reset gives 240x240 and no store clearing pass; unwritten pixels read as
//  whatever the store holds. a stalled result holds in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dda_line_framebuffer_draw #(
  parameter int STORE_PIXELS = 65536,
  parameter int FRAC_BITS    = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire dlfb_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output dlfb_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_we,
  input  wire logic [dlfb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dlfb_pkg::DIM_W-1:0]       cfg_wdata
);

  logic [dlfb_pkg::DIM_W-1:0] frame_width_r, frame_height_r;
  logic                       q_push, q_full, q_pop, q_empty;
  dlfb_pkg::cmd_t             q_wdata, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= dlfb_pkg::FRAME_DIM_RESET;
      frame_height_r <= dlfb_pkg::FRAME_DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dlfb_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        dlfb_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  dlfb_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  dlfb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  dlfb_back #(
    .STORE_PIXELS (STORE_PIXELS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/dlfb_queue.sv =====
// ----------------------------------------------------------------------------
// dlfb_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlfb_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire dlfb_pkg::cmd_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output dlfb_pkg::cmd_t      head
);

  dlfb_pkg::cmd_t                 slot_r [dlfb_pkg::QDEPTH];
  logic [dlfb_pkg::QAW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [dlfb_pkg::QAW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [dlfb_pkg::QCW-1:0]       cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign full    = (cnt_r == dlfb_pkg::QCW'(dlfb_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dlfb_front.sv =====
// ----------------------------------------------------------------------------
// dlfb_front
// takes items, finds line length and per-axis steps with a bit-serial divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlfb_front #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire dlfb_pkg::in_item_t in_data,
  output logic                    q_push,
  output dlfb_pkg::cmd_t          q_data,
  input  wire logic               q_full
);

  localparam int NW = FRAC_BITS + dlfb_pkg::COORD_W;
  localparam int CW = $clog2(NW);

  dlfb_pkg::fr_state_t          state_r, state_nxt;
  dlfb_pkg::in_item_t           item_r;
  logic [dlfb_pkg::COORD_W-1:0] len_r;
  logic [dlfb_pkg::COORD_W-1:0] ax_c, ay_c, len_c;
  logic                         sx_r, sy_r;
  logic [NW-1:0]                numx_r, numy_r;
  logic [dlfb_pkg::COORD_W-1:0] remx_r, remy_r;
  logic [CW-1:0]                cnt_r;
  logic [dlfb_pkg::COORD_W:0]   trialx, trialy, len_ext;
  logic                         gex, gey;
  logic                         accept, skip_div, div_last;
  logic [FRAC_BITS:0]           qx, qy;

  // magnitudes of the endpoint differences
  always_comb begin
    ax_c  = (item_r.x_end >= item_r.x_start) ? item_r.x_end - item_r.x_start
                                             : item_r.x_start - item_r.x_end;
    ay_c  = (item_r.y_end >= item_r.y_start) ? item_r.y_end - item_r.y_start
                                             : item_r.y_start - item_r.y_end;
    len_c = (ax_c > ay_c) ? ax_c : ay_c;
  end

  // one restoring step on both axes
  always_comb begin
    len_ext = {1'b0, len_r};
    trialx  = {remx_r, numx_r[NW-1]};
    trialy  = {remy_r, numy_r[NW-1]};
    gex     = (trialx >= len_ext);
    gey     = (trialy >= len_ext);
  end

  assign accept   = in_valid && !in_stall;
  assign skip_div = (item_r.mode == dlfb_pkg::MODE_READ) || (len_c == '0);
  assign div_last = (cnt_r == CW'(NW - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dlfb_pkg::FR_IDLE: begin
        if (in_valid) begin
          state_nxt = dlfb_pkg::FR_PREP;
        end
      end
      dlfb_pkg::FR_PREP: begin
        state_nxt = skip_div ? dlfb_pkg::FR_PUSH : dlfb_pkg::FR_DIV;
      end
      dlfb_pkg::FR_DIV: begin
        if (div_last) begin
          state_nxt = dlfb_pkg::FR_PUSH;
        end
      end
      dlfb_pkg::FR_PUSH: begin
        if (!q_full) begin
          state_nxt = dlfb_pkg::FR_IDLE;
        end
      end
      default: state_nxt = dlfb_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state_r != dlfb_pkg::FR_IDLE);
    q_push       = (state_r == dlfb_pkg::FR_PUSH) && !q_full;
    qx           = numx_r[FRAC_BITS:0];
    qy           = numy_r[FRAC_BITS:0];
    q_data.rd    = (item_r.mode == dlfb_pkg::MODE_READ);
    q_data.x0    = item_r.x_start;
    q_data.y0    = item_r.y_start;
    q_data.len   = len_r;
    q_data.stx   = sx_r ? -dlfb_pkg::STEP_W'(qx) : dlfb_pkg::STEP_W'(qx);
    q_data.sty   = sy_r ? -dlfb_pkg::STEP_W'(qy) : dlfb_pkg::STEP_W'(qy);
    q_data.color = item_r.color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dlfb_pkg::FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    case (state_r)
      dlfb_pkg::FR_PREP: begin
        sx_r   <= (item_r.x_end < item_r.x_start);
        sy_r   <= (item_r.y_end < item_r.y_start);
        remx_r <= '0;
        remy_r <= '0;
        cnt_r  <= '0;
        if (skip_div) begin
          numx_r <= '0;
          numy_r <= '0;
          len_r  <= (item_r.mode == dlfb_pkg::MODE_READ) ? dlfb_pkg::COORD_W'(1) : '0;
        end else begin
          numx_r <= NW'(ax_c) << FRAC_BITS;
          numy_r <= NW'(ay_c) << FRAC_BITS;
          len_r  <= len_c;
        end
      end
      dlfb_pkg::FR_DIV: begin
        remx_r <= gex ? dlfb_pkg::COORD_W'(trialx - len_ext) : dlfb_pkg::COORD_W'(trialx);
        remy_r <= gey ? dlfb_pkg::COORD_W'(trialy - len_ext) : dlfb_pkg::COORD_W'(trialy);
        numx_r <= {numx_r[NW-2:0], gex};
        numy_r <= {numy_r[NW-2:0], gey};
        cnt_r  <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dlfb_back.sv =====
// ----------------------------------------------------------------------------
// dlfb_back
// walks the line one point per cycle, clips, writes or reads the pixel store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlfb_back #(
  parameter int STORE_PIXELS = 65536,
  parameter int FRAC_BITS    = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [dlfb_pkg::DIM_W-1:0]   frame_width,
  input  wire logic [dlfb_pkg::DIM_W-1:0]   frame_height,
  input  wire logic                         q_empty,
  input  wire dlfb_pkg::cmd_t               q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output dlfb_pkg::out_item_t               out_data
);

  localparam int AW = $clog2(STORE_PIXELS);
  localparam int PW = FRAC_BITS + dlfb_pkg::COORD_W;

  dlfb_pkg::bk_state_t          state_r, state_nxt;
  dlfb_pkg::cmd_t               cmd_r;
  logic [PW-1:0]                px_r, py_r;
  logic [dlfb_pkg::COORD_W-1:0] k_r;
  logic [dlfb_pkg::COORD_W-1:0] count_r;
  logic [dlfb_pkg::COORD_W-1:0] cx, cy;
  logic                         issue, load_out;

  logic                         s1_v_r, s1_rd_r, s1_inframe_r;
  logic [dlfb_pkg::COORD_W-1:0] s1_cx_r;
  logic [dlfb_pkg::PROD_W-1:0]  s1_prod_r;
  logic [dlfb_pkg::IDX_W-1:0]   idx;
  logic                         in_store, do_wr, do_rd;

  logic [dlfb_pkg::COLOR_W-1:0] mem [STORE_PIXELS];
  logic [dlfb_pkg::COLOR_W-1:0] rd_data_r, rdval_r;
  logic                         s2_v_r, s2_ok_r;

  logic                         out_valid_r;
  dlfb_pkg::out_item_t          out_item_r;

  assign cx = px_r[PW-1:FRAC_BITS];
  assign cy = py_r[PW-1:FRAC_BITS];

  // store index and range check on stage one
  always_comb begin
    idx      = dlfb_pkg::IDX_W'(s1_cx_r) + dlfb_pkg::IDX_W'(s1_prod_r);
    in_store = (idx < dlfb_pkg::IDX_W'(STORE_PIXELS));
    do_wr    = s1_v_r && !s1_rd_r && s1_inframe_r && in_store;
    do_rd    = s1_v_r && s1_rd_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dlfb_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = dlfb_pkg::BK_ISSUE;
        end
      end
      dlfb_pkg::BK_ISSUE: begin
        if (k_r == cmd_r.len) begin
          state_nxt = dlfb_pkg::BK_FLUSH;
        end
      end
      dlfb_pkg::BK_FLUSH: begin
        if (!s1_v_r && !s2_v_r) begin
          state_nxt = dlfb_pkg::BK_DONE;
        end
      end
      dlfb_pkg::BK_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = dlfb_pkg::BK_IDLE;
        end
      end
      default: state_nxt = dlfb_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state_r == dlfb_pkg::BK_IDLE) && !q_empty;
    issue    = (state_r == dlfb_pkg::BK_ISSUE) && (k_r != cmd_r.len);
    load_out = (state_r == dlfb_pkg::BK_DONE) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dlfb_pkg::BK_IDLE;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= issue;
      s2_v_r  <= do_rd;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // point walk
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r   <= q_head;
      px_r    <= PW'(q_head.x0) << FRAC_BITS;
      py_r    <= PW'(q_head.y0) << FRAC_BITS;
      k_r     <= '0;
      count_r <= '0;
    end else begin
      if (issue) begin
        px_r <= px_r + PW'(cmd_r.stx);
        py_r <= py_r + PW'(cmd_r.sty);
        k_r  <= k_r + 1'b1;
      end
      if (do_wr) begin
        count_r <= count_r + 1'b1;
      end
    end
    if (issue) begin
      s1_rd_r      <= cmd_r.rd;
      s1_cx_r      <= cx;
      s1_prod_r    <= cy * frame_width;
      s1_inframe_r <= ({1'b0, cx} < frame_width) && ({1'b0, cy} < frame_height);
    end
    if (s2_v_r) begin
      rdval_r <= s2_ok_r ? rd_data_r : '0;
    end
    if (load_out) begin
      out_item_r.pixel_value    <= cmd_r.rd ? rdval_r : '0;
      out_item_r.pixels_written <= cmd_r.rd ? '0 : count_r;
    end
  end

  // pixel store
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[idx[AW-1:0]] <= cmd_r.color;
    end
    rd_data_r <= mem[idx[AW-1:0]];
    s2_ok_r   <= in_store;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

// ===== verif/dda_line_framebuffer_draw_tb.sv =====
// ----------------------------------------------------------------------------
// dda_line_framebuffer_draw_tb
// directed and random line draws and pixel reads checked against a dda
// line predictor with its own pixel store, over several frame sizes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dda_line_framebuffer_draw_tb;

  localparam int STORE_PIXELS = 65536;
  localparam int FRAC_BITS = 8;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 236;
  localparam int SETTLE_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam int FRAME_W_LIST [PHASES] = '{1024, 1, 1024, 0, 2047, 320, 64, 0};
  localparam int FRAME_H_LIST [PHASES] = '{1024, 1024, 1, 300, 2047, 200, 1000, 0};

  class line_scoreboard;
    dlfb_pkg::out_item_t awaited[$];
    bit [dlfb_pkg::COLOR_W-1:0] pixels [int unsigned];
    int unsigned painted[$];
    int unsigned frame_w = dlfb_pkg::FRAME_DIM_RESET;
    int unsigned frame_h = dlfb_pkg::FRAME_DIM_RESET;
    int mismatches = 0;
    int checked = 0;
    int draws = 0;
    int reads = 0;
    longint points = 0;

    function void set_frame(int unsigned w, int unsigned h);
      frame_w = w;
      frame_h = h;
    endfunction

    function int unsigned trace_line(dlfb_pkg::in_item_t it);
      longint dx, dy, ay, steps, stx, sty, px, py, cx, cy, fw, fh, k;
      int unsigned idx;
      int unsigned n;
      n = 0;
      fw = frame_w;
      fh = frame_h;
      dx = longint'(it.x_end) - longint'(it.x_start);
      dy = longint'(it.y_end) - longint'(it.y_start);
      steps = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ay > steps) steps = ay;
      if (steps == 0) return 0;
      stx = (dx <<< FRAC_BITS) / steps;
      sty = (dy <<< FRAC_BITS) / steps;
      px = longint'(it.x_start) <<< FRAC_BITS;
      py = longint'(it.y_start) <<< FRAC_BITS;
      for (k = 0; k < steps; k++) begin
        cx = px >>> FRAC_BITS;
        cy = py >>> FRAC_BITS;
        if (cx >= 0 && cy >= 0 && cx < fw && cy < fh && cx + cy * fw < STORE_PIXELS) begin
          idx = int'(cx + cy * fw);
          if (!pixels.exists(idx)) painted.push_back(idx);
          pixels[idx] = it.color;
          n++;
          points++;
        end
        px += stx;
        py += sty;
      end
      return n;
    endfunction

    function void note_item(dlfb_pkg::in_item_t it);
      dlfb_pkg::out_item_t want;
      longint idx;
      want = '0;
      if (it.mode == dlfb_pkg::MODE_DRAW) begin
        want.pixels_written = dlfb_pkg::COORD_W'(trace_line(it));
        draws++;
      end else begin
        idx = longint'(it.x_start) + longint'(it.y_start) * longint'(frame_w);
        if (idx < STORE_PIXELS && pixels.exists(int'(idx)))
          want.pixel_value = pixels[int'(idx)];
        reads++;
      end
      awaited.push_back(want);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch: %s", what);
    endtask

    task check_result(dlfb_pkg::out_item_t got);
      dlfb_pkg::out_item_t want;
      checked++;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing outstanding", got));
        return;
      end
      want = awaited.pop_front();
      if (got.pixel_value !== want.pixel_value)
        report_mismatch($sformatf("result %0d pixel_value %h, expected %h",
                                  checked, got.pixel_value, want.pixel_value));
      if (got.pixels_written !== want.pixels_written)
        report_mismatch($sformatf("result %0d pixels_written %0d, expected %0d",
                                  checked, got.pixels_written, want.pixels_written));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  dlfb_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dlfb_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [dlfb_pkg::CFG_IDX_W-1:0] cfg_index = dlfb_pkg::CFG_FRAME_WIDTH;
  logic [dlfb_pkg::DIM_W-1:0] cfg_wdata = dlfb_pkg::FRAME_DIM_RESET;

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;
  line_scoreboard sb;

  dda_line_framebuffer_draw dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** dda_line_framebuffer_draw: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  task automatic set_idling(input int sel);
    case (sel % 4)
      0: begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_gap_pct = 62;
        recv_stall_pct = 0;
      end
      2: begin
        send_gap_pct = 0;
        recv_stall_pct = 62;
      end
      default: begin
        send_gap_pct = 32;
        recv_stall_pct = 32;
      end
    endcase
  endtask

  task automatic send_item(input dlfb_pkg::in_item_t it);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame(input logic [dlfb_pkg::DIM_W-1:0] w,
                             input logic [dlfb_pkg::DIM_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= dlfb_pkg::CFG_FRAME_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= dlfb_pkg::CFG_FRAME_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_frame(w, h);
  endtask

  function automatic dlfb_pkg::in_item_t make_item(logic m, int xs, int ys, int xe, int ye,
                                                   int c);
    dlfb_pkg::in_item_t it;
    it.mode = m;
    it.x_start = dlfb_pkg::COORD_W'(xs);
    it.y_start = dlfb_pkg::COORD_W'(ys);
    it.x_end = dlfb_pkg::COORD_W'(xe);
    it.y_end = dlfb_pkg::COORD_W'(ye);
    it.color = dlfb_pkg::COLOR_W'(c);
    return it;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  function automatic dlfb_pkg::in_item_t random_item();
    dlfb_pkg::in_item_t it;
    int unsigned fw, fh, roll, idx, span, xlim, ylim, lo, hi, min_x;
    int xs, ys, xe, ye;
    fw = sb.frame_w;
    fh = sb.frame_h;
    it = make_item(dlfb_pkg::MODE_READ, 0, 0, $urandom, $urandom, $urandom);
    roll = $urandom_range(99);
    if (roll < 38 && sb.painted.size() != 0) begin
      // beyond the store
      if (roll < 5 && 1023 + 1023 * fw >= STORE_PIXELS) begin
        lo = (STORE_PIXELS - 1023 + fw - 1) / fw;
        hi = $urandom_range(1023, lo);
        min_x = (hi * fw < STORE_PIXELS) ? STORE_PIXELS - hi * fw : 0;
        it.y_start = dlfb_pkg::COORD_W'(hi);
        it.x_start = dlfb_pkg::COORD_W'($urandom_range(1023, min_x));
        return it;
      end
      idx = sb.painted[$urandom_range(sb.painted.size() - 1)];
      if (fw == 0) begin
        if (idx <= 1023) begin
          it.x_start = dlfb_pkg::COORD_W'(idx);
          it.y_start = dlfb_pkg::COORD_W'($urandom);
          return it;
        end
      end else begin
        hi = idx / fw;
        if (hi > 1023) hi = 1023;
        lo = (idx > 1023) ? (idx - 1023 + fw - 1) / fw : 0;
        if (lo <= hi) begin
          ys = $urandom_range(hi, lo);
          it.y_start = dlfb_pkg::COORD_W'(ys);
          it.x_start = dlfb_pkg::COORD_W'(idx - ys * fw);
          return it;
        end
      end
    end
    xlim = (fw + 3 > 1023) ? 1023 : fw + 3;
    ylim = (fh + 3 > 1023) ? 1023 : fh + 3;
    if ($urandom_range(99) < 80) begin
      xs = $urandom_range(xlim);
      ys = $urandom_range(ylim);
    end else begin
      xs = $urandom_range(1023);
      ys = $urandom_range(1023);
    end
    roll = $urandom_range(99);
    span = (roll < 82) ? 20 : (roll < 95) ? 120 : (roll < 99) ? 400 : 1023;
    xe = clamp_coord(xs + int'($urandom_range(2 * span)) - int'(span));
    ye = clamp_coord(ys + int'($urandom_range(2 * span)) - int'(span));
    if ($urandom_range(99) < 4) begin
      xe = xs;
      ye = ys;
    end
    return make_item(dlfb_pkg::MODE_DRAW, xs, ys, xe, ye, $urandom);
  endfunction

  initial begin
    dlfb_pkg::in_item_t directed[$];
    int p, i, w, h;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset frame of 240x240, store empty
    directed.push_back(make_item(dlfb_pkg::MODE_DRAW, 5, 5, 5, 5, 'h1234));
    directed.push_back(make_item(dlfb_pkg::MODE_DRAW, 0, 0, 10, 0, 'hffff));
    directed.push_back(make_item(dlfb_pkg::MODE_READ, 0, 0, 1023, 1023, 'hffff));
    directed.push_back(make_item(dlfb_pkg::MODE_READ, 9, 0, 0, 0, 0));
    directed.push_back(make_item(dlfb_pkg::MODE_DRAW, 0, 4, 239, 4, 'h0f0f));
    directed.push_back(make_item(dlfb_pkg::MODE_READ, 500, 2, 7, 9, 'h1111));
    directed.push_back(make_item(dlfb_pkg::MODE_DRAW, 3, 20, 3, 0, 0));
    directed.push_back(make_item(dlfb_pkg::MODE_DRAW, 0, 0, 1023, 1023, 'ha5a5));
    directed.push_back(make_item(dlfb_pkg::MODE_DRAW, 1023, 1023, 0, 0, 'h5a5a));
    directed.push_back(make_item(dlfb_pkg::MODE_DRAW, 0, 100, 1023, 0, 'h3c3c));
    directed.push_back(make_item(dlfb_pkg::MODE_DRAW, 1023, 0, 0, 1023, 'hc3c3));
    directed.push_back(make_item(dlfb_pkg::MODE_DRAW, 500, 500, 600, 700, 'h7777));
    directed.push_back(make_item(dlfb_pkg::MODE_DRAW, 10, 10, 12, 50, 'h1111));
    directed.push_back(make_item(dlfb_pkg::MODE_DRAW, 10, 10, 12, 50, 'h2222));
    directed.push_back(make_item(dlfb_pkg::MODE_READ, 10, 30, 0, 0, 0));
    directed.push_back(make_item(dlfb_pkg::MODE_READ, 1023, 1023, 1023, 1023, 'hffff));
    directed.push_back(make_item(dlfb_pkg::MODE_DRAW, 1023, 1023, 1023, 1023, 'hffff));
    directed.push_back(make_item(dlfb_pkg::MODE_DRAW, 239, 239, 245, 250, 'h00ff));
    directed.push_back(make_item(dlfb_pkg::MODE_READ, 238, 4, 0, 0, 0));
    directed.push_back(make_item(dlfb_pkg::MODE_READ, 0, 0, 0, 0, 0));
    foreach (directed[j]) send_item(directed[j]);
    wait_drained;

    for (p = 0; p < PHASES; p++) begin
      w = FRAME_W_LIST[p];
      h = FRAME_H_LIST[p];
      if (p == PHASES - 1) begin
        w = $urandom_range(1024, 1);
        h = $urandom_range(1024, 1);
      end
      write_frame(dlfb_pkg::DIM_W'(w), dlfb_pkg::DIM_W'(h));
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == 0) set_idling(p);
        if (i == ITEMS_PER_PHASE / 2) set_idling(p + 1);
        // sender holds off until the engine has emptied
        if (p == 2 && i == 100) wait_drained;
        send_item(random_item());
      end
      wait_drained;
    end

    if (sb.awaited.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.awaited.size()));
    $display("covered %0d line draws storing %0d pixels and %0d pixel reads",
             sb.draws, sb.points, sb.reads);
    $display("over %0d frame sizes, %0d results checked, %0d mismatches",
             PHASES + 1, sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("** dda_line_framebuffer_draw: PASSED **");
    end else begin
      $display("** dda_line_framebuffer_draw: FAILED **");
    end
    $finish;
  end

endmodule
